@@ rtl/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, datapath operation codes and status bundle for the
// first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

	localparam int HEAP_UNITS_DEF = 1024;
	localparam int UNIT_BYTES_DEF = 4;

	localparam int SIZE_W   = 16;
	localparam int HANDLE_W = 10;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd2;

	// header index width: must hold the null value and any handle - 1
	function automatic int idx_width(input int heap_units);
		int w;
		w = $clog2(heap_units) + 1;
		return (w > HANDLE_W) ? w : HANDLE_W;
	endfunction

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_ZERO,
		OP_NOFIT,
		OP_DIV,
		OP_A_RD,
		OP_A_NEXT,
		OP_A_EXACT,
		OP_A_SPLIT1,
		OP_A_SPLIT2,
		OP_F_HEAD,
		OP_F_RD,
		OP_F_NEXT,
		OP_F_RDM,
		OP_F_MERGE,
		OP_F_E,
		OP_F_LINK,
		OP_J_RD,
		OP_J_RDB,
		OP_J_LINK,
		OP_J_MERGE
	} op_t;

	typedef struct packed {
		logic kind_free;
		logic size_zero;
		logic hin_zero;
		logic ff_gt_m;
		logic cur_nil;
		logic cur_lt_m;
		logic cur_eq_m;
		logic prev_nil;
		logic steps_lim;
		logic fits;
		logic exact;
		logic adj_m;
		logic e_hit;
		logic adj_j;
	} dp_stat_t;

endpackage

@@ rtl/ffa_datapath.sv @@
// ----------------------------------------------------------------------------
// ffa_datapath
// Header memories, list pointers, size-to-units conversion and result registers.
// Executes one operation code per cycle from the controller.
// ----------------------------------------------------------------------------
module ffa_datapath #(
	parameter int HEAP_UNITS = ffa_pkg::HEAP_UNITS_DEF,
	parameter int UNIT_BYTES = ffa_pkg::UNIT_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ffa_pkg::op_t                  op,
	input  logic                          kind,
	input  logic [ffa_pkg::SIZE_W-1:0]    size_bytes,
	input  logic [ffa_pkg::HANDLE_W-1:0]  handle_in,
	output ffa_pkg::dp_stat_t             stat,
	output logic [ffa_pkg::HANDLE_W-1:0]  handle_out,
	output logic [ffa_pkg::STATUS_W-1:0]  status
);

	localparam int AW = $clog2(HEAP_UNITS);
	localparam int IW = ffa_pkg::idx_width(HEAP_UNITS);
	localparam int EW = IW + 1;
	localparam int NW = ffa_pkg::SIZE_W + 2;
	localparam int CW = ((IW > NW) ? IW : NW) + 1;
	localparam int SW = $clog2(HEAP_UNITS + 1);
	// reciprocal of the unit size, exact for every 16-bit dividend
	localparam int DL = $clog2(UNIT_BYTES);
	localparam int DS = ffa_pkg::SIZE_W + DL;
	localparam int MW = DS + 1;
	localparam int PW = ffa_pkg::SIZE_W + MW;
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << DS) + 64'(UNIT_BYTES) - 64'd1) / 64'(UNIT_BYTES));
	localparam logic [IW-1:0] NIL      = IW'(HEAP_UNITS);
	localparam logic [IW-1:0] LEN0_RST = IW'(HEAP_UNITS - 1);

	logic [IW-1:0] len_mem  [HEAP_UNITS];
	logic [IW-1:0] link_mem [HEAP_UNITS];

	logic                       kind_q, zero_q, hzero_q;
	logic [IW-1:0]              m_q, cur_q, prev_q, ff_q, a_q, b_q, h_q;
	logic [IW-1:0]              lnx_q, lknx_q, la_q, newlen_q;
	logic [SW-1:0]              steps_q;
	logic [ffa_pkg::SIZE_W-1:0] quo_q;
	logic [ffa_pkg::HANDLE_W-1:0] handle_q;
	logic [ffa_pkg::STATUS_W-1:0] status_q;

	logic                w0_len_q, w0_link_q;
	logic [IW-1:0]       len_raw_q, link_raw_q;
	logic                oob_q, rst_len_q, rst_link_q;

	logic [IW-1:0]       rd_idx;
	logic                len_we, link_we;
	logic [IW-1:0]       len_wa, len_wd, link_wa, link_wd;

	logic [IW-1:0]       rd_len, rd_link;
	logic [NW-1:0]       need;
	logic [CW-1:0]       len_c, need_c;
	logic [EW-1:0]       cur_plus_len, a_plus_len, merge_len, e_sum, split_h;
	logic [IW-1:0]       cut_len;
	logic [PW-1:0]       quo_prod;

	// read data with reset value for unit 0 and range check
	always_comb begin
		rd_len  = oob_q ? '0  : (rst_len_q  ? LEN0_RST : len_raw_q);
		rd_link = oob_q ? NIL : (rst_link_q ? NIL      : link_raw_q);
	end

	always_comb begin
		need         = NW'(quo_q) + NW'(2);
		len_c        = CW'(rd_len);
		need_c       = CW'(need);
		cut_len      = IW'(len_c - need_c);
		split_h      = EW'(cur_q) + EW'(cut_len);
		cur_plus_len = EW'(cur_q) + EW'(rd_len);
		a_plus_len   = EW'(a_q) + EW'(rd_len);
		merge_len    = EW'(lnx_q) + EW'(rd_len);
		e_sum        = EW'(cur_q) + EW'(IW'(merge_len));
		quo_prod     = PW'(quo_q) * PW'(RECIP);
	end

	always_comb begin
		stat.kind_free = kind_q;
		stat.size_zero = zero_q;
		stat.hin_zero  = hzero_q;
		stat.ff_gt_m   = ff_q > m_q;
		stat.cur_nil   = cur_q == NIL;
		stat.cur_lt_m  = cur_q < m_q;
		stat.cur_eq_m  = cur_q == m_q;
		stat.prev_nil  = prev_q == NIL;
		stat.steps_lim = steps_q >= SW'(HEAP_UNITS);
		stat.fits      = len_c >= need_c;
		stat.exact     = len_c == need_c;
		stat.adj_m     = cur_plus_len == EW'(m_q);
		stat.e_hit     = (e_sum != EW'(NIL)) && (e_sum == EW'(lknx_q));
		stat.adj_j     = (b_q != NIL) && (a_plus_len == EW'(b_q));
	end

	// memory port control
	always_comb begin
		rd_idx  = cur_q;
		len_we  = 1'b0;
		link_we = 1'b0;
		len_wa  = cur_q;
		len_wd  = '0;
		link_wa = prev_q;
		link_wd = rd_link;
		case (op)
			ffa_pkg::OP_F_RDM:   rd_idx = m_q;
			ffa_pkg::OP_F_MERGE: begin
				rd_idx = IW'(e_sum);
				len_we = 1'b1;
				len_wd = IW'(merge_len);
			end
			ffa_pkg::OP_F_E: begin
				len_we  = 1'b1;
				len_wd  = IW'(EW'(newlen_q) + EW'(rd_len));
				link_we = 1'b1;
				link_wa = cur_q;
			end
			ffa_pkg::OP_F_LINK: begin
				link_we = 1'b1;
				link_wd = m_q;
			end
			ffa_pkg::OP_J_RD:    rd_idx = m_q;
			ffa_pkg::OP_J_RDB:   rd_idx = b_q;
			ffa_pkg::OP_J_LINK: begin
				link_we = 1'b1;
				link_wa = a_q;
				link_wd = b_q;
			end
			ffa_pkg::OP_J_MERGE: begin
				len_we  = 1'b1;
				len_wa  = a_q;
				len_wd  = IW'(EW'(la_q) + EW'(rd_len));
				link_we = 1'b1;
				link_wa = a_q;
			end
			ffa_pkg::OP_A_EXACT: link_we = (prev_q != NIL);
			ffa_pkg::OP_A_SPLIT1: begin
				len_we = 1'b1;
				len_wd = cut_len;
			end
			ffa_pkg::OP_A_SPLIT2: begin
				len_we = 1'b1;
				len_wa = h_q;
				len_wd = IW'(need);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (len_we && len_wa < IW'(HEAP_UNITS))
			len_mem[len_wa[AW-1:0]] <= len_wd;
		if (link_we && link_wa < IW'(HEAP_UNITS))
			link_mem[link_wa[AW-1:0]] <= link_wd;
		len_raw_q  <= len_mem[rd_idx[AW-1:0]];
		link_raw_q <= link_mem[rd_idx[AW-1:0]];
	end

	// unit 0 keeps its reset header until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_len_q   <= 1'b0;
			w0_link_q  <= 1'b0;
			oob_q      <= 1'b0;
			rst_len_q  <= 1'b0;
			rst_link_q <= 1'b0;
		end else begin
			if (len_we && len_wa == '0)
				w0_len_q <= 1'b1;
			if (link_we && link_wa == '0)
				w0_link_q <= 1'b1;
			oob_q      <= rd_idx >= IW'(HEAP_UNITS);
			rst_len_q  <= (rd_idx == '0) && !w0_len_q;
			rst_link_q <= (rd_idx == '0) && !w0_link_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_q     <= '0;
			handle_q <= '0;
			status_q <= ffa_pkg::ST_DONE;
		end else begin
			case (op)
				ffa_pkg::OP_LOAD: begin
					handle_q <= '0;
					status_q <= ffa_pkg::ST_DONE;
				end
				ffa_pkg::OP_ZERO:    status_q <= ffa_pkg::ST_ZERO;
				ffa_pkg::OP_NOFIT:   status_q <= ffa_pkg::ST_NOFIT;
				ffa_pkg::OP_A_EXACT: begin
					if (prev_q == NIL)
						ff_q <= rd_link;
					handle_q <= ffa_pkg::HANDLE_W'(cur_q + IW'(1));
				end
				ffa_pkg::OP_A_SPLIT1: handle_q <= ffa_pkg::HANDLE_W'(split_h + EW'(1));
				ffa_pkg::OP_F_HEAD:   ff_q <= m_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			ffa_pkg::OP_LOAD: begin
				kind_q  <= kind;
				zero_q  <= size_bytes == '0;
				hzero_q <= handle_in == '0;
				quo_q   <= size_bytes - ffa_pkg::SIZE_W'(1);
				m_q     <= IW'(handle_in) - IW'(1);
				cur_q   <= ff_q;
				prev_q  <= NIL;
				steps_q <= '0;
			end
			// divide by the unit size through the reciprocal
			ffa_pkg::OP_DIV: quo_q <= quo_prod[DS +: ffa_pkg::SIZE_W];
			ffa_pkg::OP_A_NEXT, ffa_pkg::OP_F_NEXT: begin
				prev_q <= cur_q;
				cur_q  <= rd_link;
			end
			ffa_pkg::OP_A_RD:     steps_q <= steps_q + SW'(1);
			ffa_pkg::OP_F_RD:     steps_q <= steps_q + SW'(1);
			ffa_pkg::OP_A_SPLIT1: h_q <= IW'(split_h);
			ffa_pkg::OP_F_HEAD: begin
				a_q <= m_q;
				b_q <= ff_q;
			end
			ffa_pkg::OP_F_RDM: begin
				lnx_q  <= rd_len;
				lknx_q <= rd_link;
			end
			ffa_pkg::OP_F_MERGE: newlen_q <= IW'(merge_len);
			ffa_pkg::OP_F_LINK: begin
				a_q <= m_q;
				b_q <= cur_q;
			end
			ffa_pkg::OP_J_RDB: la_q <= rd_len;
			default: ;
		endcase
	end

	assign handle_out = handle_q;
	assign status     = status_q;

endmodule

@@ rtl/ffa_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for allocate and free requests: size conversion, list walk,
// split, unlink, insert and coalesce.
// ----------------------------------------------------------------------------
module ffa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ffa_pkg::dp_stat_t stat,
	output ffa_pkg::op_t      op,
	output logic              busy,
	output logic              done
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_DIV,
		S_A_RD,
		S_A_CHK,
		S_A_SPLIT2,
		S_F_RD,
		S_F_CHK,
		S_F_M,
		S_F_E,
		S_J_RD,
		S_J_CHK,
		S_J_MERGE
	} state_t;

	state_t         state_q, state_d;
	logic           fin;
	logic           done_q;

	always_comb begin
		op      = ffa_pkg::OP_NONE;
		state_d = state_q;
		fin     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op      = ffa_pkg::OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (!stat.kind_free) begin
					if (stat.size_zero) begin
						op  = ffa_pkg::OP_ZERO;
						fin = 1'b1;
					end else begin
						state_d = S_DIV;
					end
				end else if (stat.hin_zero) begin
					fin = 1'b1;
				end else if (stat.ff_gt_m) begin
					op      = ffa_pkg::OP_F_HEAD;
					state_d = S_J_RD;
				end else begin
					state_d = S_F_RD;
				end
			end
			S_DIV: begin
				op      = ffa_pkg::OP_DIV;
				state_d = S_A_RD;
			end
			S_A_RD: begin
				if (stat.cur_nil || stat.steps_lim) begin
					op  = ffa_pkg::OP_NOFIT;
					fin = 1'b1;
				end else begin
					op      = ffa_pkg::OP_A_RD;
					state_d = S_A_CHK;
				end
			end
			S_A_CHK: begin
				if (stat.fits && stat.exact) begin
					op  = ffa_pkg::OP_A_EXACT;
					fin = 1'b1;
				end else if (stat.fits) begin
					op      = ffa_pkg::OP_A_SPLIT1;
					state_d = S_A_SPLIT2;
				end else begin
					op      = ffa_pkg::OP_A_NEXT;
					state_d = S_A_RD;
				end
			end
			S_A_SPLIT2: begin
				op  = ffa_pkg::OP_A_SPLIT2;
				fin = 1'b1;
			end
			S_F_RD: begin
				if (!stat.cur_nil && stat.cur_lt_m) begin
					if (stat.steps_lim) begin
						fin = 1'b1;
					end else begin
						op      = ffa_pkg::OP_F_RD;
						state_d = S_F_CHK;
					end
				end else if (stat.cur_eq_m || stat.prev_nil) begin
					// already listed, nothing to do
					fin = 1'b1;
				end else begin
					op      = ffa_pkg::OP_F_LINK;
					state_d = S_J_RD;
				end
			end
			S_F_CHK: begin
				if (stat.adj_m) begin
					op      = ffa_pkg::OP_F_RDM;
					state_d = S_F_M;
				end else begin
					op      = ffa_pkg::OP_F_NEXT;
					state_d = S_F_RD;
				end
			end
			S_F_M: begin
				op = ffa_pkg::OP_F_MERGE;
				if (stat.e_hit)
					state_d = S_F_E;
				else
					fin = 1'b1;
			end
			S_F_E: begin
				op  = ffa_pkg::OP_F_E;
				fin = 1'b1;
			end
			S_J_RD: begin
				op      = ffa_pkg::OP_J_RD;
				state_d = S_J_CHK;
			end
			S_J_CHK: begin
				if (stat.adj_j) begin
					op      = ffa_pkg::OP_J_RDB;
					state_d = S_J_MERGE;
				end else begin
					op  = ffa_pkg::OP_J_LINK;
					fin = 1'b1;
				end
			end
			S_J_MERGE: begin
				op  = ffa_pkg::OP_J_MERGE;
				fin = 1'b1;
			end
			default: state_d = S_IDLE;
		endcase
		if (fin)
			state_d = S_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

endmodule

@@ rtl/first_fit_free_list_allocator_top.sv @@
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_top
// First-fit heap allocator over header memories, with coalescing on free.
// ----------------------------------------------------------------------------
// Usage: present kind, size_bytes and handle_in with start high; the item is
// taken on the rising edge where start is high and busy is low. busy stays
// high until the result is out. The result (handle_out, status) is valid for
// the single cycle where done is high; the receiver cannot stall it, so it
// must take it then. Allocate: dispatch, the reciprocal size-to-units
// multiply, then a read and a check step per free block visited, the fitting
// one too; an exact fit ends at its check, a split then writes the second
// header, and no fit ends at the list end or the walk limit. A zero-size
// allocate or a free of handle zero ends at dispatch. A free below the list
// head becomes the head, merging with the old one if adjacent. Otherwise it
// walks the blocks below it the same way, then merges into the block below
// if adjacent (and the next one too if adjacent), ends if already listed,
// or links in, merging with the block above if adjacent. Each walk step is
// bound by the one registered read port of the header memories. Items are
// handled one at a time; a new start is taken in the done cycle.
// Reset: the heap is one free block at unit 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_top #(
	parameter int HEAP_UNITS = ffa_pkg::HEAP_UNITS_DEF,
	parameter int UNIT_BYTES = ffa_pkg::UNIT_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [ffa_pkg::SIZE_W-1:0]    size_bytes,
	input  logic [ffa_pkg::HANDLE_W-1:0]  handle_in,
	output logic                          done,
	output logic [ffa_pkg::HANDLE_W-1:0]  handle_out,
	output logic [ffa_pkg::STATUS_W-1:0]  status
);

	ffa_pkg::op_t      op;
	ffa_pkg::dp_stat_t stat;

	ffa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.op     (op),
		.busy   (busy),
		.done   (done)
	);

	ffa_datapath #(
		.HEAP_UNITS (HEAP_UNITS),
		.UNIT_BYTES (UNIT_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.kind       (kind),
		.size_bytes (size_bytes),
		.handle_in  (handle_in),
		.stat       (stat),
		.handle_out (handle_out),
		.status     (status)
	);

endmodule
